>>> rtl/audio_peak_level_meter_assert.svh
// Assertion macros for the peak level meter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef AUDIO_PEAK_LEVEL_METER_ASSERT_SVH
`define AUDIO_PEAK_LEVEL_METER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define APLM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define APLM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APLM_ASSERT_IMP(label, ante, cons)
`define APLM_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/aplm_pkg.sv
package aplm_pkg;

    // Sample format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S8  = 3'd1;
    localparam logic [2:0] FMT_U16 = 3'd2;
    localparam logic [2:0] FMT_S16 = 3'd3;
    localparam logic [2:0] FMT_U32 = 3'd4;
    localparam logic [2:0] FMT_S32 = 3'd5;
    localparam logic [2:0] FMT_F32 = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_ENDIAN = 2'd1;

    localparam logic [2:0] FORMAT_RESET = FMT_S16;

    localparam int SAMPLE_W = 32;
    localparam int LEVEL_W  = 16;

    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic peak_update;
        logic peak_clear;
        logic div_load;
        logic div_step;
        logic out_load;
    } aplm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fmt_valid;
    } aplm_status_t;

    // Full scale of a format; zero for the unused code
    function automatic logic [31:0] full_scale(input logic [2:0] code);
        logic [31:0] fs;
        case (code)
            FMT_U8:  fs = 32'd255;
            FMT_S8:  fs = 32'd127;
            FMT_U16: fs = 32'd65535;
            FMT_S16: fs = 32'd32767;
            FMT_U32: fs = 32'hffff_ffff;
            FMT_S32: fs = SAT_POS;
            FMT_F32: fs = SAT_POS;
            default: fs = 32'd0;
        endcase
        return fs;
    endfunction

endpackage

>>> rtl/aplm_datapath.sv
module aplm_datapath #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [31:0]           sample_bits,
    input  aplm_pkg::aplm_cmd_t   cmd,
    output aplm_pkg::aplm_status_t status,
    output logic [31:0]           peak,
    output logic [15:0]           level
);
    import aplm_pkg::*;

    localparam int DW = SAMPLE_W + LEVEL_BITS;

    logic [2:0]            fmt_reg;
    logic                  be_reg;
    logic [31:0]           peak_reg;
    logic [31:0]           pk_reg;
    logic [31:0]           rem_reg;
    logic [LEVEL_BITS-1:0] low_reg;
    logic [LEVEL_BITS-1:0] q_reg;
    logic [31:0]           peak_out_reg;
    logic [15:0]           level_out_reg;

    logic [31:0] fs;
    logic [15:0] sw16;
    logic [31:0] sw32;
    logic [7:0]  m8;
    logic [15:0] m16;
    logic [31:0] m32;
    logic [31:0] fmag;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [7:0]  sh_l;
    logic [7:0]  sh_r;
    logic [31:0] fl_shift;
    logic [31:0] mag;
    logic [31:0] clamp;
    logic [DW-1:0] dvd;
    logic [32:0] trial;
    logic        ge;

    assign fs = full_scale(fmt_reg);
    assign status.fmt_valid = (fs != 32'd0);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FORMAT_RESET;
            be_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: fmt_reg <= cfg_data[2:0];
                REG_ENDIAN: be_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Byte order and magnitudes of the integer formats
    assign sw16 = be_reg ? {sample_bits[7:0], sample_bits[15:8]} : sample_bits[15:0];
    assign sw32 = be_reg ? {sample_bits[7:0], sample_bits[15:8],
                            sample_bits[23:16], sample_bits[31:24]} : sample_bits;
    assign m8  = sample_bits[7] ? 8'(8'd0 - sample_bits[7:0]) : sample_bits[7:0];
    assign m16 = sw16[15] ? 16'(16'd0 - sw16) : sw16;
    assign m32 = sw32[31] ? 32'(32'd0 - sw32) : sw32;

    // Float to fixed: trunc(|f| * 2^31), saturated
    assign expo = sw32[30:23];
    assign mant = {1'b1, sw32[22:0]};
    assign sh_l = 8'(expo - 8'd119);
    assign sh_r = 8'(8'd119 - expo);

    always_comb
    begin
        fl_shift = 32'd0;
        if (expo == 8'hff)
            fmag = SAT_POS;
        else if (expo == 8'd0)
            fmag = 32'd0;
        else if (expo >= 8'd119)
        begin
            if (sh_l > 8'd8)
                fmag = SAT_POS;
            else
            begin
                fl_shift = {8'd0, mant} << sh_l[3:0];
                fmag = fl_shift[31] ? SAT_POS : fl_shift;
            end
        end
        else if (sh_r >= 8'd32)
            fmag = 32'd0;
        else
        begin
            fl_shift = {8'd0, mant} >> sh_r[4:0];
            fmag = fl_shift;
        end
    end

    // Pick the magnitude for the format
    always_comb
    begin
        case (fmt_reg)
            FMT_U8:  mag = {24'd0, sample_bits[7:0]};
            FMT_S8:  mag = {24'd0, m8};
            FMT_U16: mag = {16'd0, sw16};
            FMT_S16: mag = {16'd0, m16};
            FMT_U32: mag = sw32;
            FMT_S32: mag = m32;
            FMT_F32: mag = fmag;
            default: mag = 32'd0;
        endcase
    end

    // Running peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_reg <= 32'd0;
        else if (cmd.peak_clear)
            peak_reg <= 32'd0;
        else if (cmd.peak_update && (mag > peak_reg))
            peak_reg <= mag;
    end

    // Clamp and form peak * (2^LEVEL_BITS - 1)
    assign clamp = (peak_reg > fs) ? fs : peak_reg;
    assign dvd   = {clamp, LEVEL_BITS'(0)} - DW'(clamp);

    // One restoring division step
    assign trial = {rem_reg, low_reg[LEVEL_BITS-1]};
    assign ge    = (trial >= {1'b0, fs});

    // Divider and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            pk_reg  <= clamp;
            rem_reg <= dvd[DW-1:LEVEL_BITS];
            low_reg <= dvd[LEVEL_BITS-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, fs}) : trial[31:0];
            low_reg <= {low_reg[LEVEL_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[LEVEL_BITS-2:0], ge};
        end
        if (cmd.out_load)
        begin
            peak_out_reg  <= pk_reg;
            level_out_reg <= LEVEL_W'(q_reg);
        end
    end

    assign peak  = peak_out_reg;
    assign level = level_out_reg;

endmodule

>>> rtl/aplm_ctrl.sv
module aplm_ctrl #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  aplm_pkg::aplm_status_t status,
    output aplm_pkg::aplm_cmd_t    cmd
);
    import aplm_pkg::*;

    `include "audio_peak_level_meter_assert.svh"

    localparam int CW = $clog2(LEVEL_BITS + 1);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          in_acc;
    logic          slot_free;

    assign in_ready  = (state_reg == S_RUN);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequence: accept samples, load divider, iterate, hand over result
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd.peak_update = 1'b0;
        cmd.peak_clear  = 1'b0;
        cmd.div_load    = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.out_load    = 1'b0;
        unique case (state_reg)
            S_RUN:
            begin
                if (in_acc)
                begin
                    cmd.peak_update = 1'b1;
                    if (in_last)
                    begin
                        if (status.fmt_valid)
                            state_next = S_LOAD;
                        else
                            cmd.peak_clear = 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.div_load   = 1'b1;
                cmd.peak_clear = 1'b1;
                cnt_next       = '0;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = CW'(cnt_reg + 1'b1);
                if (cnt_reg == CW'(LEVEL_BITS - 1))
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    // Output word valid: set on load, drop on handoff
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `APLM_ASSERT_NXT(a_load_shows_valid, cmd.out_load, out_valid_reg)
    `APLM_ASSERT_IMP(a_load_slot_free, cmd.out_load, !out_valid_reg || out_ready)
    `APLM_ASSERT_IMP(a_cnt_bound, state_reg == S_DIV, cnt_reg < CW'(LEVEL_BITS))
    `APLM_ASSERT_NXT(a_last_starts_div, in_acc && in_last && status.fmt_valid,
        state_reg == S_LOAD && !in_ready)

endmodule

>>> rtl/audio_peak_level_meter.sv
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata sample_bits, tlast last_in_buffer
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata peak, level
// cfg      in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Samples stream back to back within a buffer, one per cycle.
// After a buffer's last sample in a valid format, the meter clamps the peak and loads
// the divider, runs LEVEL_BITS steps of the restoring divider, then hands over.
// The result sits in an output register, so the next buffer starts while it waits.
// Reset clears the running peak and sets format s16, little endian.
// A stalled output holds the divider result until the slot frees up.
module audio_peak_level_meter #(
    parameter int LEVEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
    input  logic        s_axis_tlast,   // last_in_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] peak, [47:32] level
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import aplm_pkg::*;

    aplm_cmd_t    cmd;
    aplm_status_t status;
    logic [31:0]  peak;
    logic [15:0]  level;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {level, peak};

    aplm_ctrl #(
        .LEVEL_BITS(LEVEL_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aplm_datapath #(
        .LEVEL_BITS(LEVEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_bits(s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .peak       (peak),
        .level      (level)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import aplm_pkg::*;

    // Format code with no full scale
    localparam logic [2:0] FMT_UNUSED = 3'd7;

    // Register indexes that decode to nothing
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    localparam int          SETTLE_CYCLES = 2 + LEVEL_W + 8;
    localparam int unsigned RANDOM_ITEMS  = 1300;
    localparam int unsigned MAX_GAP       = 6;
    localparam longint      TIMEOUT_NS    = 2_000_000;
    localparam logic [63:0] LEVEL_MAX     = (64'd1 << LEVEL_W) - 64'd1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] sample_bits
    logic        s_axis_tlast = 1'b0;   // last_in_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [31:0] peak, [47:32] level
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // Shadow of the meter's registers and running peak
    logic [2:0]  meter_format = FORMAT_RESET;
    logic        meter_big_endian = 1'b0;
    logic [31:0] meter_peak = '0;

    // Results still owed by the meter, oldest first
    logic [31:0] peak_due [$];
    logic [15:0] level_due [$];

    int unsigned errors = 0;
    int unsigned rx_hold = 0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;

    audio_peak_level_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned pick_gap(input logic calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [31:0] flip32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] format_full_scale(input logic [2:0] fmt);
        case (fmt)
            FMT_U8:  return 32'd255;
            FMT_S8:  return 32'd127;
            FMT_U16: return 32'd65535;
            FMT_S16: return 32'd32767;
            FMT_U32: return 32'hffff_ffff;
            FMT_S32: return 32'h7fff_ffff;
            FMT_F32: return 32'h7fff_ffff;
            default: return 32'd0;
        endcase
    endfunction

    // Scale |f| by 2^31 and truncate, saturating at 2^31-1
    function automatic logic [31:0] float_to_q31(input logic [31:0] f);
        int          ex;
        logic [63:0] m;
        ex = int'({24'd0, f[30:23]});
        m  = {40'd0, 1'b1, f[22:0]};
        if (ex == 255)
            return 32'h7fff_ffff;
        if (ex == 0)
            return 32'd0;
        if (ex >= 119)
        begin
            if (ex - 119 > 8)
                return 32'h7fff_ffff;
            m = m << (ex - 119);
        end
        else
        begin
            if (119 - ex >= 32)
                return 32'd0;
            m = m >> (119 - ex);
        end
        return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    function automatic logic [31:0] sample_magnitude(input logic [31:0] raw);
        logic [15:0] h;
        logic [31:0] w;
        h = meter_big_endian ? {raw[7:0], raw[15:8]} : raw[15:0];
        w = meter_big_endian ? flip32(raw) : raw;
        case (meter_format)
            FMT_U8:  return {24'd0, raw[7:0]};
            FMT_S8:  return raw[7] ? 32'h100 - {24'd0, raw[7:0]} : {24'd0, raw[7:0]};
            FMT_U16: return {16'd0, h};
            FMT_S16: return h[15] ? 32'h10000 - {16'd0, h} : {16'd0, h};
            FMT_U32: return w;
            FMT_S32: return w[31] ? 32'd0 - w : w;
            FMT_F32: return float_to_q31(w);
            default: return 32'd0;
        endcase
    endfunction

    // Fold one accepted sample into the shadow peak; queue a result on last
    function automatic void track_sample(input logic [31:0] raw, input logic last);
        logic [31:0] fs;
        logic [31:0] mag;
        logic [31:0] pk;
        logic [63:0] lvl;
        fs = format_full_scale(meter_format);
        if (fs == 32'd0)
        begin
            if (last)
                meter_peak = 32'd0;
            return;
        end
        mag = sample_magnitude(raw);
        if (mag > meter_peak)
            meter_peak = mag;
        if (!last)
            return;
        pk  = (meter_peak > fs) ? fs : meter_peak;
        lvl = ({32'd0, pk} * LEVEL_MAX) / {32'd0, fs};
        peak_due.push_back(pk);
        level_due.push_back(lvl[15:0]);
        meter_peak = 32'd0;
    endfunction

    // Random raw bytes for a format, mostly meaningful magnitudes in lane order
    function automatic logic [31:0] random_sample(input logic [2:0] fmt, input logic be);
        logic [31:0] v;
        logic [31:0] junk;
        logic [15:0] h;
        int unsigned ex;
        junk = $urandom;
        case ($urandom_range(0, 9))
            0: v = 32'd0;
            1: v = 32'hffff_ffff;
            2:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_8000;
                    3: v = 32'h0000_7fff;
                    4: v = 32'h0000_0080;
                    5: v = 32'h0000_007f;
                    default: v = 32'h0000_0001;
                endcase
            end
            3, 4: return $urandom;
            default:
            begin
                if (fmt == FMT_F32)
                begin
                    ex = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(100, 128);
                    v  = {junk[31], ex[7:0], junk[22:0]};
                end
                else
                begin
                    v = $urandom >> $urandom_range(0, 31);
                    if ($urandom_range(0, 1) == 1)
                        v = ~v;
                end
            end
        endcase
        case (fmt)
            FMT_U8, FMT_S8:
                return {junk[31:8], v[7:0]};
            FMT_U16, FMT_S16:
            begin
                h = be ? {v[7:0], v[15:8]} : v[15:0];
                return {junk[31:16], h};
            end
            FMT_U32, FMT_S32, FMT_F32:
                return be ? flip32(v) : v;
            default:
                return junk;
        endcase
    endfunction

    // Offer one sample word after a random gap and wait for it to go in
    task automatic send_sample(input logic [31:0] bits, input logic last);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_sample(bits, last);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FORMAT)
            meter_format = data[2:0];
        else if (idx == REG_ENDIAN)
            meter_big_endian = data[0];
    endtask

    // Write both registers; with noise set, fill unused bits and sometimes hit a spare index
    task automatic configure(input logic [2:0] fmt, input logic be, input logic noise);
        logic [7:0] data;
        data      = noise ? 8'($urandom) : 8'd0;
        data[2:0] = fmt;
        write_reg(REG_FORMAT, data);
        data      = noise ? 8'($urandom) : 8'd0;
        data[0]   = be;
        write_reg(REG_ENDIAN, data);
        if (noise && $urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every owed result is out and the divider is quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (peak_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_state();
        // Most negative s16 clamps to full scale
        send_sample(32'h0000_8000, 1'b1);
        send_sample(32'hdead_1234, 1'b0);
        send_sample(32'h0000_fffe, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
    endtask

    task automatic test_integer_formats();
        drain();
        configure(FMT_U8, 1'b0, 1'b0);
        send_sample(32'habcd_ef00, 1'b0);
        send_sample(32'h1234_56ff, 1'b1);
        drain();
        configure(FMT_S8, 1'b0, 1'b0);
        send_sample(32'h0000_0080, 1'b1);
        drain();
        configure(FMT_U16, 1'b1, 1'b0);
        send_sample(32'hffff_0100, 1'b1);
        drain();
        configure(FMT_S16, 1'b1, 1'b0);
        send_sample(32'h0000_0080, 1'b1);
        drain();
        configure(FMT_U32, 1'b0, 1'b0);
        send_sample(32'hffff_ffff, 1'b1);
        drain();
        configure(FMT_U32, 1'b1, 1'b0);
        send_sample(32'h7856_3412, 1'b1);
        drain();
        configure(FMT_S32, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'hffff_ffff, 1'b1);
    endtask

    task automatic test_float_cases();
        drain();
        configure(FMT_F32, 1'b0, 1'b0);
        // Infinity, NaN, subnormal, 1.0, -0.5, smallest nonzero, truncated to zero
        send_sample(32'h7f80_0000, 1'b1);
        send_sample(32'hffc0_0001, 1'b1);
        send_sample(32'h807f_ffff, 1'b1);
        send_sample(32'h3f80_0000, 1'b1);
        send_sample(32'hbf00_0000, 1'b1);
        send_sample(32'h3000_0000, 1'b1);
        send_sample(32'h2f80_0000, 1'b1);
        drain();
        configure(FMT_F32, 1'b1, 1'b0);
        send_sample(32'h0000_003f, 1'b1);
    endtask

    task automatic test_unused_format();
        drain();
        configure(FMT_U8, 1'b0, 1'b0);
        send_sample(32'h0000_00ff, 1'b0);
        drain();
        // Unused code ignores samples; its last word only clears the peak
        configure(FMT_UNUSED, 1'b0, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        drain();
        configure(FMT_U8, 1'b0, 1'b0);
        send_sample(32'h0000_0010, 1'b1);
    endtask

    task automatic test_random_buffers();
        logic [2:0]  sweep [7];
        logic [2:0]  fmt;
        logic        be;
        int unsigned phase;
        int unsigned sent;
        int unsigned quota;
        int unsigned len;
        sweep = '{FMT_U8, FMT_S8, FMT_U16, FMT_S16, FMT_U32, FMT_S32, FMT_F32};
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Sweep every format in both byte orders first, then the unused code, then pick at random
            if (phase < 14)
            begin
                fmt = sweep[phase / 2];
                be  = phase[0];
            end
            else if (phase == 14 || $urandom_range(0, 15) == 0)
            begin
                fmt = FMT_UNUSED;
                be  = 1'($urandom_range(0, 1));
            end
            else
            begin
                fmt = sweep[$urandom_range(0, 6)];
                be  = 1'($urandom_range(0, 1));
            end
            drain();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            configure(fmt, be, 1'b1);
            quota = $urandom_range(30, 80);
            while (quota != 0)
            begin
                len = $urandom_range(1, 12);
                if (len > quota)
                    len = quota;
                repeat (len - 1)
                    send_sample(random_sample(fmt, be), 1'b0);
                send_sample(random_sample(fmt, be), 1'b1);
                quota -= len;
                sent  += len;
            end
            phase++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Stall the result side for a random number of cycles after each word
    always @(posedge clk)
    begin
        int unsigned hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            hold = pick_gap(rx_calm);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold       <= hold;
            end
        end
        else if (!m_axis_tready)
        begin
            if (rx_hold <= 1)
                m_axis_tready <= 1'b1;
            if (rx_hold != 0)
                rx_hold <= rx_hold - 1;
        end
    end

    // Compare each result word with the oldest owed result
    always @(posedge clk)
    begin
        logic [31:0] want_peak;
        logic [15:0] want_level;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (peak_due.size() == 0)
            begin
                $error("unexpected result: peak %0d, level %0d",
                       m_axis_tdata[31:0], m_axis_tdata[47:32]);
                errors++;
            end
            else
            begin
                want_peak  = peak_due.pop_front();
                want_level = level_due.pop_front();
                if (m_axis_tdata[31:0] !== want_peak)
                begin
                    $error("peak: expected %0d, actual %0d", want_peak, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== want_level)
                begin
                    $error("level: expected %0d, actual %0d",
                           want_level, m_axis_tdata[47:32]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_integer_formats();
        test_float_cases();
        test_unused_format();
        test_random_buffers();
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/aplm_pkg.sv
rtl/aplm_datapath.sv
rtl/aplm_ctrl.sv
rtl/audio_peak_level_meter.sv
tb/tb.sv
